### hdl/atmw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package atmw_pkg;

  // Window geometry
  localparam int WINDOW = 15;
  localparam int IDX_W  = $clog2(WINDOW);

  // Converter code and millivolt entry
  localparam int CODE_W      = 12;
  localparam int MV_W        = 13;
  localparam int SCALE_Q16   = 79201;  // 3300 / 4096 / 0.66666 in unsigned Q16
  localparam int SCALE_W     = 17;
  localparam int SCALE_SHIFT = 16;
  localparam int PROD_W      = CODE_W + SCALE_W;
  localparam int MV_MAX      = (((1 << CODE_W) - 1) * SCALE_Q16) >> SCALE_SHIFT;

  // Window sum and trimmed divide by reciprocal
  localparam int SUM_W        = $clog2(WINDOW * MV_MAX + 1);
  localparam int TRIM_DIV     = WINDOW - 2;
  localparam int RECIP_SHIFT  = 24;
  localparam int RECIP        = ((1 << RECIP_SHIFT) + TRIM_DIV - 1) / TRIM_DIV;
  localparam int RECIP_W      = RECIP_SHIFT + 1;
  localparam int QPROD_W      = SUM_W + RECIP_W;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [MV_W-1:0]   mv_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SUM_W-1:0]  sum_t;

endpackage

`default_nettype wire

### hdl/atmw_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface atmw_in_if;
  logic                  valid;
  logic                  ready;
  logic [atmw_pkg::CODE_W-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

interface atmw_out_if;
  logic                  valid;
  logic                  ready;
  logic [atmw_pkg::MV_W-1:0] filtered_mv;

  modport source (output valid, output filtered_mv, input ready);
  modport sink   (input valid, input filtered_mv, output ready);
endinterface

`default_nettype wire

### hdl/atmw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module atmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/adc_trimmed_mean_window.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted word passes through S_WRITE, S_SWEEP, S_TRIM and S_DIV (which holds until the
//   result register is free) before its result is registered on out_ch. No new word is taken
//   until then; the sweep walks the sample memory, one read port, one entry per cycle.
// Reset: synchronous, active low; clears the ring valid bits (entries read as zero until
//   written), the write index and both handshakes. No clearing pass is needed.

module adc_trimmed_mean_window (
  input wire logic   clk,
  input wire logic   rst_n,
  atmw_in_if.sink    in_ch,
  atmw_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_SWEEP,
    S_TRIM,
    S_DIV
  } state_t;

  state_t state_r;

  // Input code held for the write cycle
  atmw_pkg::code_t code_r;

  // Ring bookkeeping: write pointer and per-entry valid bits
  atmw_pkg::idx_t                    wr_idx_r;
  logic [atmw_pkg::WINDOW-1:0]       vld_r;

  // Sweep control: issue address, pending read and its address
  atmw_pkg::idx_t rd_idx_r;
  logic           iss_done_r;
  logic           pend_r;
  atmw_pkg::idx_t paddr_r;

  // Running statistics
  atmw_pkg::sum_t sum_r;
  atmw_pkg::mv_t  max_r;
  atmw_pkg::mv_t  min_r;
  atmw_pkg::sum_t trim_r;

  // Result register
  logic          out_valid_r;
  atmw_pkg::mv_t out_mv_r;

  // Datapath
  logic [atmw_pkg::PROD_W-1:0]  scale_prod;
  atmw_pkg::mv_t                scaled_mv;
  atmw_pkg::mv_t                ram_q;
  atmw_pkg::mv_t                rd_val;
  atmw_pkg::sum_t               sum_nxt;
  atmw_pkg::mv_t                max_nxt;
  atmw_pkg::mv_t                min_nxt;
  logic [atmw_pkg::QPROD_W-1:0] qprod;
  logic                         ram_we;
  logic                         out_free;

  // Scale code to millivolts: (code * 79201) >> 16, truncated
  assign scale_prod = atmw_pkg::PROD_W'(code_r) * atmw_pkg::PROD_W'(atmw_pkg::SCALE_Q16);
  assign scaled_mv  = scale_prod[atmw_pkg::SCALE_SHIFT +: atmw_pkg::MV_W];

  assign ram_we = (state_r == S_WRITE);

  atmw_ram #(
    .WIDTH (atmw_pkg::MV_W),
    .DEPTH (atmw_pkg::WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (scaled_mv),
    .raddr (rd_idx_r),
    .rdata (ram_q)
  );

  // Entries never written since reset count as zero
  assign rd_val = vld_r[paddr_r] ? ram_q : '0;

  always_comb begin
    sum_nxt = sum_r + atmw_pkg::SUM_W'(rd_val);
    max_nxt = (rd_val > max_r) ? rd_val : max_r;
    min_nxt = (rd_val < min_r) ? rd_val : min_r;
  end

  // Divide by WINDOW - 2 through a scaled reciprocal; exact for every reachable sum
  assign qprod = atmw_pkg::QPROD_W'(trim_r) *
                 atmw_pkg::QPROD_W'(atmw_pkg::RECIP_W'(atmw_pkg::RECIP));

  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.filtered_mv = out_mv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_idx_r    <= '0;
      vld_r       <= '0;
      iss_done_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result word once taken, unless S_DIV refills it this cycle
      if (out_valid_r && out_ch.ready && state_r != S_DIV) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            code_r  <= in_ch.adc_code;
            state_r <= S_WRITE;
          end
        end

        S_WRITE: begin
          // Store scaled sample, advance the ring pointer, arm the sweep
          vld_r[wr_idx_r] <= 1'b1;
          wr_idx_r        <= (wr_idx_r == atmw_pkg::IDX_W'(atmw_pkg::WINDOW - 1)) ?
                             '0 : wr_idx_r + 1'b1;
          rd_idx_r        <= '0;
          iss_done_r      <= 1'b0;
          pend_r          <= 1'b0;
          sum_r           <= '0;
          max_r           <= '0;
          min_r           <= '1;
          state_r         <= S_SWEEP;
        end

        S_SWEEP: begin
          // Issue one read per cycle; fold in the word that returns
          pend_r  <= !iss_done_r;
          paddr_r <= rd_idx_r;
          if (!iss_done_r) begin
            if (rd_idx_r == atmw_pkg::IDX_W'(atmw_pkg::WINDOW - 1)) begin
              iss_done_r <= 1'b1;
            end else begin
              rd_idx_r <= rd_idx_r + 1'b1;
            end
          end
          if (pend_r) begin
            sum_r <= sum_nxt;
            max_r <= max_nxt;
            min_r <= min_nxt;
            if (paddr_r == atmw_pkg::IDX_W'(atmw_pkg::WINDOW - 1)) begin
              state_r <= S_TRIM;
            end
          end
        end

        S_TRIM: begin
          // Remove one copy of the largest and one of the smallest entry
          pend_r  <= 1'b0;
          trim_r  <= sum_r - atmw_pkg::SUM_W'(max_r) - atmw_pkg::SUM_W'(min_r);
          state_r <= S_DIV;
        end

        S_DIV: begin
          // Hold until the result register is free
          if (out_free) begin
            out_mv_r    <= qprod[atmw_pkg::RECIP_SHIFT +: atmw_pkg::MV_W];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_to_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_WRITE)
    else $error("accepted word did not start a ring write");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_mv_r <= atmw_pkg::MV_W'(atmw_pkg::MV_MAX))
    else $error("filtered value above full-scale millivolts");

  a_wr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_idx_r <= atmw_pkg::IDX_W'(atmw_pkg::WINDOW - 1))
    else $error("ring write index out of window");

  a_pend_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == S_SWEEP)
    else $error("memory read returned outside the sweep");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |=> vld_r[$past(wr_idx_r)])
    else $error("written ring entry not marked valid");
`endif

endmodule

`default_nettype wire
